>>> hdl/lph_pkg.sv
// Shared types and constants for the linear-probe hash table.
// Used by the front end, the back end and the top level; no dependencies.
package lph_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 16;
  localparam int VAL_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 7;
  localparam int PROBE_W    = 8;

  // Hash product and reciprocal remainder
  localparam int PROD_W     = 2 * KEY_W;
  localparam int RED_STEPS  = 3;
  localparam int STEP_W     = $clog2(RED_STEPS);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    RS_INSERTED  = 3'd0,
    RS_FULL      = 3'd1,
    RS_FOUND     = 3'd2,
    RS_NOT_FOUND = 3'd3,
    RS_DELETED   = 3'd4,
    RS_DEL_MISS  = 3'd5
  } res_e;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'd0,
    SL_USED  = 2'd1,
    SL_TOMB  = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL
  } back_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } item_t;

endpackage

>>> hdl/lph_front.sv
// Front end: takes one transaction, squares the key and reduces it to the
// home slot, then hands the item to the command queue. Depends on lph_pkg.
module lph_front #(
  parameter int TABLE_SIZE = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [lph_pkg::OP_W-1:0]   opcode_i,
  input  logic [lph_pkg::KEY_W-1:0]  key_i,
  input  logic [lph_pkg::VAL_W-1:0]  value_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output lph_pkg::item_t             q_item_o,
  output logic [$clog2(TABLE_SIZE)-1:0] q_home_o
);
  import lph_pkg::*;

  localparam int  IDX_W   = $clog2(TABLE_SIZE);
  localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam int  RED_SHIFT = PROD_W + IDX_W;
  localparam logic [PROD_W:0] RECIP =
    (PROD_W+1)'((64'd1 << RED_SHIFT) / TABLE_SIZE);

  front_e               state_q, state_d;
  item_t                item_q, item_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [IDX_W:0]       diff_q, diff_d;
  logic [IDX_W-1:0]     rem_q, rem_d;
  logic [STEP_W-1:0]    step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    diff_q <= diff_d;
    rem_q  <= rem_d;
  end

  always_comb begin
    logic [2*PROD_W:0] qm;
    state_d  = state_q;
    item_d   = item_q;
    prod_d   = prod_q;
    quo_d    = quo_q;
    diff_d   = diff_q;
    rem_d    = rem_q;
    step_d   = step_q;
    full_o   = 1'b1;
    q_push_o = 1'b0;
    qm       = (2*PROD_W+1)'(prod_q) * (2*PROD_W+1)'(RECIP);
    case (state_q)
      F_IDLE: begin
        full_o = 1'b0;
        if (push_i) begin
          item_d.op  = opcode_i;
          item_d.key = key_i;
          item_d.val = value_i;
          state_d    = F_MUL;
        end
      end
      F_MUL: begin
        prod_d  = PROD_W'(item_q.key) * PROD_W'(item_q.key);
        rem_d   = '0;
        step_d  = '0;
        state_d = IS_POW2 ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        // estimate the quotient by reciprocal, form the remainder, then
        // correct it once; the estimate is never more than one too small
        step_d = step_q + 1'b1;
        if (step_q == '0) begin
          quo_d = PROD_W'(qm >> RED_SHIFT);
        end else if (step_q == STEP_W'(1)) begin
          diff_d = (IDX_W+1)'(prod_q - PROD_W'(quo_q * PROD_W'(TABLE_SIZE)));
        end else begin
          rem_d   = (diff_q >= (IDX_W+1)'(TABLE_SIZE)) ?
                    IDX_W'(diff_q - (IDX_W+1)'(TABLE_SIZE)) : diff_q[IDX_W-1:0];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign q_item_o = item_q;
  assign q_home_o = IS_POW2 ? prod_q[IDX_W-1:0] : rem_q;

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIV |=> state_q == F_DIV || state_q == F_PUSH)
    else $error("front left the remainder loop early");

  a_home_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> IS_POW2 || (IDX_W+1)'(rem_q) < (IDX_W+1)'(TABLE_SIZE))
    else $error("home slot outside the table");

endmodule

>>> hdl/lph_fifo.sv
// Small command queue between the front end and the back end.
// Generic width; no package dependency.
module lph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/lph_back.sv
// Back end: walks the probe sequence through the slot memory, applies the
// insert, search or delete and holds the result register. Depends on lph_pkg.
module lph_back #(
  parameter int TABLE_SIZE = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  lph_pkg::item_t                q_item_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] q_home_i,
  output logic                          q_pop_o,
  output logic                          res_valid_o,
  input  logic                          res_pop_i,
  output logic [lph_pkg::STATUS_W-1:0]  status_o,
  output logic [lph_pkg::SLOT_W-1:0]    slot_o,
  output logic [lph_pkg::PROBE_W-1:0]   probes_o
);
  import lph_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);

  typedef struct packed {
    slot_e            st;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } entry_t;

  entry_t slot_mem [TABLE_SIZE];
  entry_t rd_q;

  back_e                 state_q, state_d;
  logic [IDX_W-1:0]      addr_q, addr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  item_t                 item_q, item_d;

  logic                  res_valid_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic [PROBE_W-1:0]    res_probes_q;

  logic                  can_emit, emit;
  logic [STATUS_W-1:0]   e_status;
  logic [SLOT_W-1:0]     e_slot;
  logic [PROBE_W-1:0]    e_probes;
  logic                  wr_en;
  entry_t                wr_data;
  logic [IDX_W-1:0]      addr_next;

  assign can_emit  = !res_valid_q || res_pop_i;
  assign addr_next = (addr_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : addr_q + 1'b1;

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[addr_q] <= wr_data;
    end
    rd_q <= slot_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      addr_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (emit) begin
      res_status_q <= e_status;
      res_slot_q   <= e_slot;
      res_probes_q <= e_probes;
    end
  end

  always_comb begin
    logic done, wr_req, last;
    state_d  = state_q;
    addr_d   = addr_q;
    cnt_d    = cnt_q;
    item_d   = item_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    wr_en    = 1'b0;
    wr_data  = rd_q;
    e_status = RS_NOT_FOUND;
    e_slot   = '0;
    e_probes = PROBE_W'(cnt_q);
    done     = 1'b0;
    wr_req   = 1'b0;
    last     = cnt_q == CNT_W'(TABLE_SIZE);
    case (state_q)
      B_CLEAR: begin
        // sweep every slot to empty after reset
        wr_en          = 1'b1;
        wr_data.st     = SL_EMPTY;
        wr_data.key    = '0;
        wr_data.val    = '0;
        addr_d         = addr_next;
        if (addr_q == IDX_W'(TABLE_SIZE - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          if (q_item_i.op == OP_INSERT || q_item_i.op == OP_SEARCH ||
              q_item_i.op == OP_DELETE) begin
            q_pop_o = 1'b1;
            item_d  = q_item_i;
            addr_d  = q_home_i;
            cnt_d   = '0;
            state_d = B_READ;
          end else if (can_emit) begin
            // unused opcode: no probes, no state change
            q_pop_o  = 1'b1;
            emit     = 1'b1;
            e_status = RS_NOT_FOUND;
            e_probes = '0;
          end
        end
      end
      B_READ: begin
        cnt_d   = cnt_q + 1'b1;
        state_d = B_EVAL;
      end
      B_EVAL: begin
        case (item_q.op)
          OP_INSERT: begin
            if (rd_q.st != SL_USED) begin
              done        = 1'b1;
              wr_req      = 1'b1;
              wr_data.st  = SL_USED;
              wr_data.key = item_q.key;
              wr_data.val = item_q.val;
              e_status    = RS_INSERTED;
              e_slot      = SLOT_W'(addr_q);
            end else if (last) begin
              done     = 1'b1;
              e_status = RS_FULL;
            end
          end
          OP_SEARCH, OP_DELETE: begin
            e_status = (item_q.op == OP_DELETE) ? RS_DEL_MISS : RS_NOT_FOUND;
            if (rd_q.st == SL_EMPTY) begin
              done = 1'b1;
            end else if (rd_q.key == item_q.key && item_q.op == OP_DELETE) begin
              done       = 1'b1;
              wr_req     = 1'b1;
              wr_data.st = SL_TOMB;
              e_status   = RS_DELETED;
              e_slot     = SLOT_W'(addr_q);
            end else if (rd_q.key == item_q.key && rd_q.st == SL_USED) begin
              done     = 1'b1;
              e_status = RS_FOUND;
              e_slot   = SLOT_W'(addr_q);
            end else if (last) begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          // hold here until the result register frees up
          if (can_emit) begin
            emit    = 1'b1;
            wr_en   = wr_req;
            state_d = B_IDLE;
          end
        end else begin
          addr_d  = addr_next;
          state_d = B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign slot_o      = res_slot_q;
  assign probes_o    = res_probes_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !res_valid_q || res_pop_i)
    else $error("result register overwritten before pop");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EVAL |-> cnt_q != '0 && cnt_q <= CNT_W'(TABLE_SIZE))
    else $error("probe count out of range");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CLEAR |-> !q_pop_o && !emit)
    else $error("command taken during clearing sweep");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("pop from empty command queue");

endmodule

>>> hdl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing and tombstones.
// Top level: front end, command queue and back end. Depends on lph_pkg.
//
// Input channel: present opcode_i/key_i/value_i with push; the transaction
// is taken at a clock edge with push high and full low. Opcode 0 inserts,
// 1 searches, 2 deletes. Result channel: while empty is low the oldest
// result sits on status_o/slot_o/probes_o; pop takes it. One result per
// transaction, in order.
// Timing: the front end takes a transaction, squares the key and, unless
// TABLE_SIZE is a power of two, reduces it by reciprocal remainder
// (estimate the quotient, form the remainder, correct it once), then pushes
// the item into the queue before it takes a new transaction. The back end
// takes a command, then per slot examined reads the memory, then evaluates.
// A two-entry queue lets the front end hash the next key while a probe walk runs.
// Reset: the slot memory is swept to empty, one slot per cycle, from slot 0
// to TABLE_SIZE-1; transactions are accepted and queued during the sweep.
// A stalled receiver stops the back end once its result register is full;
// the front end and queue keep accepting until the queue fills.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [lph_pkg::OP_W-1:0]     opcode_i,
  input  logic [lph_pkg::KEY_W-1:0]    key_i,
  input  logic [lph_pkg::VAL_W-1:0]    value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [lph_pkg::STATUS_W-1:0] status_o,
  output logic [lph_pkg::SLOT_W-1:0]   slot_o,
  output logic [lph_pkg::PROBE_W-1:0]  probes_o
);
  import lph_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int CMD_W  = $bits(item_t) + IDX_W;

  item_t             enq_item, deq_item;
  logic [IDX_W-1:0]  enq_home, deq_home;
  logic              enq_push, enq_full, deq_pop, deq_empty;
  logic [CMD_W-1:0]  deq_data;
  logic              res_valid;

  lph_front #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .opcode_i (opcode_i),
    .key_i    (key_i),
    .value_i  (value_i),
    .q_full_i (enq_full),
    .q_push_o (enq_push),
    .q_item_o (enq_item),
    .q_home_o (enq_home)
  );

  lph_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq_push),
    .data_i  ({enq_item, enq_home}),
    .full_o  (enq_full),
    .pop_i   (deq_pop),
    .data_o  (deq_data),
    .empty_o (deq_empty)
  );

  assign deq_item = deq_data[CMD_W-1:IDX_W];
  assign deq_home = deq_data[IDX_W-1:0];

  lph_back #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (deq_empty),
    .q_item_i    (deq_item),
    .q_home_i    (deq_home),
    .q_pop_o     (deq_pop),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .status_o    (status_o),
    .slot_o      (slot_o),
    .probes_o    (probes_o)
  );

  assign empty = !res_valid;

endmodule
